/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define BFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication: when ante holds, cons holds in the same cycle
`define BFH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bfh_pkg.sv */
package bfh_pkg;

  localparam int unsigned LEN_W = 16;
  localparam int unsigned OFS_W = 31;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W = 31;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPLIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 1'b1;

  localparam logic [LEN_W-1:0] MIN_SPLIT_RST = 16'd10;
  localparam logic [OFS_W-1:0] DATA_START_RST = 31'd0;
  // every record carries one delimiter byte
  localparam logic [OFS_W-1:0] DELIM_LEN = 31'd1;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_CMP  = 2'd1,
    OP_INS  = 2'd2,
    OP_DEL  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic             strict;
    logic [LEN_W-1:0] key;
    logic [OFS_W-1:0] new_ofs;
    logic [LEN_W-1:0] new_size;
  } ctrl_t;

endpackage

/* hw/rtl/bfh_cell.sv */
module bfh_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfh_pkg::ctrl_t             ctrl_i,
  input  logic [CntW-1:0]            count_i,
  input  logic                       left_after_i,
  input  logic [bfh_pkg::OFS_W-1:0]  left_ofs_i,
  input  logic [bfh_pkg::LEN_W-1:0]  left_size_i,
  input  logic [bfh_pkg::OFS_W-1:0]  right_ofs_i,
  input  logic [bfh_pkg::LEN_W-1:0]  right_size_i,
  output logic [bfh_pkg::OFS_W-1:0]  ofs_o,
  output logic [bfh_pkg::LEN_W-1:0]  size_o,
  output logic                       hit_o,
  output logic                       after_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(Idx);

  logic [bfh_pkg::OFS_W-1:0] ofs_q;
  logic [bfh_pkg::LEN_W-1:0] size_q;
  logic                      hit_q;
  logic                      valid;
  logic                      cmp_hit;

  assign valid   = MyIdx < count_i;
  assign cmp_hit = valid && (ctrl_i.strict ? (size_q > ctrl_i.key) : (size_q >= ctrl_i.key));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.op == bfh_pkg::OP_CMP) begin
      hit_q <= cmp_hit;
    end
  end

  // insertion point and everything past it, including the free tail
  assign after_o = hit_q || (MyIdx >= count_i);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      bfh_pkg::OP_INS: begin
        if (left_after_i) begin
          ofs_q  <= left_ofs_i;
          size_q <= left_size_i;
        end else if (after_o) begin
          ofs_q  <= ctrl_i.new_ofs;
          size_q <= ctrl_i.new_size;
        end
      end
      bfh_pkg::OP_DEL: begin
        if (hit_q) begin
          ofs_q  <= right_ofs_i;
          size_q <= right_size_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign ofs_o  = ofs_q;
  assign size_o = size_q;
  assign hit_o  = hit_q;

endmodule

/* hw/rtl/best_fit_hole_allocator_core.sv */
// Best-fit hole allocator. Free holes live in a row of FREE_SLOTS cells kept sorted by size;
// every cell compares its own entry in parallel, and inserts or removals then move entries one
// cell toward a neighbor. A transaction is taken when start_i is high and busy_o is low; its
// result is on the outputs with done_o for exactly one cycle, registered after the compare and
// execute states, and cannot be held off. Allocate, append and release keep busy_o high through
// the compare and execute states; an allocate whose leftover goes back into the table also stays
// busy through the extra compare and shift pass over the cell row (split compare, split insert).
// Writing data_start also reloads the end pointer.
`include "assert_macros.svh"

module best_fit_hole_allocator_core #(
  parameter int unsigned FREE_SLOTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bfh_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic [bfh_pkg::LEN_W-1:0]     item_length_i,
  input  logic [bfh_pkg::OFS_W-1:0]     item_offset_i,
  output logic                          done_o,
  output logic [bfh_pkg::OFS_W-1:0]     placed_offset_o,
  output logic                          reused_hole_o,
  output logic                          status_o
);

  localparam int unsigned CntW = $clog2(FREE_SLOTS + 1);
  localparam logic [CntW-1:0] SlotsMax = CntW'(FREE_SLOTS);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_CMP       = 5'b00010,
    S_EXEC      = 5'b00100,
    S_SPLIT_CMP = 5'b01000,
    S_SPLIT_INS = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic                      mode_q;
  logic [bfh_pkg::LEN_W-1:0] len_q;
  logic [bfh_pkg::OFS_W-1:0] ofs_q;
  logic [CntW-1:0]           count_q, count_d;
  logic [bfh_pkg::OFS_W-1:0] end_q, end_d;
  logic [bfh_pkg::LEN_W-1:0] min_split_q;
  logic [bfh_pkg::LEN_W-1:0] left_q, left_d;
  logic [bfh_pkg::OFS_W-1:0] left_ofs_q, left_ofs_d;
  logic                      done_q, done_d;
  logic [bfh_pkg::OFS_W-1:0] placed_q, placed_d;
  logic                      reused_q, reused_d;
  logic                      status_q, status_d;

  bfh_pkg::ctrl_t            ctrl;

  logic [bfh_pkg::OFS_W-1:0] ofs_w  [FREE_SLOTS];
  logic [bfh_pkg::LEN_W-1:0] size_w [FREE_SLOTS];
  logic [FREE_SLOTS-1:0]     hit_w;
  logic [FREE_SLOTS-1:0]     after_w;
  logic [FREE_SLOTS-1:0]     sel;
  logic [bfh_pkg::OFS_W-1:0] sel_ofs;
  logic [bfh_pkg::LEN_W-1:0] sel_size;
  logic                      found;
  logic                      full;
  logic [bfh_pkg::LEN_W:0]   left_wide;
  logic                      split_ok;

  for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
    logic                      l_after;
    logic [bfh_pkg::OFS_W-1:0] l_ofs;
    logic [bfh_pkg::LEN_W-1:0] l_size;
    logic [bfh_pkg::OFS_W-1:0] r_ofs;
    logic [bfh_pkg::LEN_W-1:0] r_size;

    if (g == 0) begin : g_first
      assign l_after = 1'b0;
      assign l_ofs   = '0;
      assign l_size  = '0;
    end else begin : g_mid
      assign l_after = after_w[g-1];
      assign l_ofs   = ofs_w[g-1];
      assign l_size  = size_w[g-1];
    end

    if (g == FREE_SLOTS - 1) begin : g_last
      assign r_ofs  = '0;
      assign r_size = '0;
    end else begin : g_inner
      assign r_ofs  = ofs_w[g+1];
      assign r_size = size_w[g+1];
    end

    bfh_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .left_after_i (l_after),
      .left_ofs_i   (l_ofs),
      .left_size_i  (l_size),
      .right_ofs_i  (r_ofs),
      .right_size_i (r_size),
      .ofs_o        (ofs_w[g]),
      .size_o       (size_w[g]),
      .hit_o        (hit_w[g]),
      .after_o      (after_w[g])
    );
  end

  // hits are monotonic along the sorted row, so the first one is where the left neighbor misses
  always_comb begin
    sel_ofs  = '0;
    sel_size = '0;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      sel[i]   = hit_w[i] && ((i == 0) ? 1'b1 : !hit_w[(i == 0) ? 0 : i-1]);
      sel_ofs  = sel_ofs | ({bfh_pkg::OFS_W{sel[i]}} & ofs_w[i]);
      sel_size = sel_size | ({bfh_pkg::LEN_W{sel[i]}} & size_w[i]);
    end
  end

  assign found     = |sel;
  assign full      = count_q >= SlotsMax;
  assign left_wide = {1'b0, sel_size} - {1'b0, len_q} - {{bfh_pkg::LEN_W{1'b0}}, 1'b1};
  assign split_ok  = found && (sel_size > len_q) &&
                     (left_wide[bfh_pkg::LEN_W-1:0] >= min_split_q);

  always_comb begin
    ctrl.op       = bfh_pkg::OP_HOLD;
    ctrl.strict   = 1'b0;
    ctrl.key      = len_q;
    ctrl.new_ofs  = ofs_q;
    ctrl.new_size = len_q;

    state_d    = state_q;
    count_d    = count_q;
    end_d      = end_q;
    left_d     = left_q;
    left_ofs_d = left_ofs_q;
    done_d     = 1'b0;
    placed_d   = placed_q;
    reused_d   = reused_q;
    status_d   = status_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.op     = bfh_pkg::OP_CMP;
        ctrl.strict = (mode_q == bfh_pkg::MODE_RELEASE);
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (mode_q == bfh_pkg::MODE_RELEASE) begin
          placed_d = '0;
          reused_d = 1'b0;
          status_d = full;
          if (!full) begin
            ctrl.op = bfh_pkg::OP_INS;
            count_d = count_q + 1'b1;
          end
        end else if (found) begin
          ctrl.op    = bfh_pkg::OP_DEL;
          count_d    = count_q - 1'b1;
          placed_d   = sel_ofs;
          reused_d   = 1'b1;
          status_d   = 1'b0;
          left_d     = left_wide[bfh_pkg::LEN_W-1:0];
          left_ofs_d = sel_ofs + bfh_pkg::OFS_W'(len_q) + bfh_pkg::DELIM_LEN;
          if (split_ok) begin
            state_d = S_SPLIT_CMP;
          end
        end else begin
          placed_d = end_q;
          reused_d = 1'b0;
          status_d = 1'b0;
          end_d    = end_q + bfh_pkg::OFS_W'(len_q) + bfh_pkg::DELIM_LEN;
        end
      end
      S_SPLIT_CMP: begin
        ctrl.op     = bfh_pkg::OP_CMP;
        ctrl.strict = 1'b1;
        ctrl.key    = left_q;
        state_d     = S_SPLIT_INS;
      end
      S_SPLIT_INS: begin
        // a slot was just freed by the removal, so there is always room
        ctrl.op       = bfh_pkg::OP_INS;
        ctrl.new_ofs  = left_ofs_q;
        ctrl.new_size = left_q;
        count_d       = count_q + 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        bfh_pkg::REG_DATA_START: end_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      end_q       <= bfh_pkg::DATA_START_RST;
      min_split_q <= bfh_pkg::MIN_SPLIT_RST;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      end_q   <= end_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bfh_pkg::REG_MIN_SPLIT: min_split_q <= cfg_wdata_i[bfh_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == S_IDLE)) begin
      mode_q <= mode_i;
      len_q  <= item_length_i;
      ofs_q  <= item_offset_i;
    end
    left_q     <= left_d;
    left_ofs_q <= left_ofs_d;
    placed_q   <= placed_d;
    reused_q   <= reused_d;
    status_q   <= status_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign placed_offset_o = placed_q;
  assign reused_hole_o   = reused_q;
  assign status_o        = status_q;

  `BFH_ASSERT(a_count_bound, count_q <= SlotsMax, "hole count beyond table size")
  `BFH_ASSERT(a_one_select, $onehot0(sel), "more than one first-fit cell selected")
  `BFH_ASSERT_IMPL(a_done_after_exec, done_o, $past(state_q) == S_EXEC, "result without execute")
  `BFH_ASSERT_IMPL(a_split_room, state_q == S_SPLIT_INS, count_q < SlotsMax, "split with full table")

endmodule

/* tb/sv/best_fit_hole_allocator_core_tb.sv */
`timescale 1ns / 1ps

module best_fit_hole_allocator_core_tb;

  localparam int unsigned FREE_SLOTS = 16;
  localparam int unsigned CYCLE_LIMIT = 500000;
  // a split allocate keeps the block busy past its result, through the split insert
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic                      mode;
    logic [bfh_pkg::LEN_W-1:0] len;
    logic [bfh_pkg::OFS_W-1:0] ofs;
  } request_t;

  typedef struct packed {
    logic [bfh_pkg::OFS_W-1:0] placed;
    logic                      reused;
    logic                      status;
  } placement_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [bfh_pkg::CFG_IDX_W-1:0] cfg_idx_i = bfh_pkg::REG_MIN_SPLIT;
  logic [bfh_pkg::CFG_W-1:0]     cfg_wdata_i = '0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic                          mode_i = bfh_pkg::MODE_ALLOC;
  logic [bfh_pkg::LEN_W-1:0]     item_length_i = '0;
  logic [bfh_pkg::OFS_W-1:0]     item_offset_i = '0;
  logic                          done_o;
  logic [bfh_pkg::OFS_W-1:0]     placed_offset_o;
  logic                          reused_hole_o;
  logic                          status_o;

  best_fit_hole_allocator_core #(
    .FREE_SLOTS(FREE_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .item_length_i  (item_length_i),
    .item_offset_i  (item_offset_i),
    .done_o         (done_o),
    .placed_offset_o(placed_offset_o),
    .reused_hole_o  (reused_hole_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted allocator state
  logic [bfh_pkg::OFS_W-1:0] free_ofs [FREE_SLOTS];
  logic [bfh_pkg::LEN_W-1:0] free_sz  [FREE_SLOTS];
  int unsigned               free_cnt = 0;
  logic [bfh_pkg::OFS_W-1:0] tail_ofs = bfh_pkg::DATA_START_RST;
  logic [bfh_pkg::LEN_W-1:0] split_min = bfh_pkg::MIN_SPLIT_RST;

  request_t   request_q[$];
  placement_t placement_q[$];

  int unsigned idle_pct = 11;
  bit          took_q = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned xfer_cnt = 0;
  int unsigned reuse_cnt = 0;
  int unsigned append_cnt = 0;
  int unsigned release_cnt = 0;
  int unsigned drop_cnt = 0;
  int unsigned phase_cnt = 0;

  // sorted insert after every hole of size <= sz
  function automatic bit insert_hole(logic [bfh_pkg::OFS_W-1:0] ofs,
                                     logic [bfh_pkg::LEN_W-1:0] sz);
    int unsigned pos;
    pos = 0;
    if (free_cnt >= FREE_SLOTS) return 1'b0;
    while (pos < free_cnt && free_sz[pos] <= sz) pos++;
    for (int unsigned k = free_cnt; k > pos; k--) begin
      free_ofs[k] = free_ofs[k-1];
      free_sz[k]  = free_sz[k-1];
    end
    free_ofs[pos] = ofs;
    free_sz[pos]  = sz;
    free_cnt++;
    return 1'b1;
  endfunction

  function automatic placement_t serve_request(request_t req);
    placement_t                res;
    int unsigned               idx;
    logic [bfh_pkg::OFS_W-1:0] hofs;
    logic [bfh_pkg::LEN_W-1:0] hsz;
    logic [bfh_pkg::LEN_W-1:0] left;
    logic [bfh_pkg::OFS_W-1:0] len_ext;
    res = '0;
    len_ext = req.len;
    if (req.mode == bfh_pkg::MODE_RELEASE) begin
      res.status = !insert_hole(req.ofs, req.len);
    end else begin
      idx = 0;
      while (idx < free_cnt && free_sz[idx] < req.len) idx++;
      if (idx < free_cnt) begin
        hofs = free_ofs[idx];
        hsz  = free_sz[idx];
        res.placed = hofs;
        res.reused = 1'b1;
        for (int unsigned k = idx; k + 1 < free_cnt; k++) begin
          free_ofs[k] = free_ofs[k+1];
          free_sz[k]  = free_sz[k+1];
        end
        free_cnt--;
        // exact fit leaves nothing to split off
        if (hsz > req.len) begin
          left = hsz - req.len - 1'b1;
          if (left >= split_min) begin
            void'(insert_hole(hofs + len_ext + bfh_pkg::DELIM_LEN, left));
          end
        end
      end else begin
        res.placed = tail_ofs;
        tail_ofs = tail_ofs + len_ext + bfh_pkg::DELIM_LEN;
      end
    end
    return res;
  endfunction

  // monitor: results, accepted transactions, register writes
  always @(posedge clk_i) begin : mon
    placement_t got;
    placement_t want;
    request_t   req;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      took_q = rst_ni && start_i && !busy_o;
      if (rst_ni && done_o) begin
        got = '{placed: placed_offset_o, reused: reused_hole_o, status: status_o};
        if (placement_q.size() == 0) begin
          $error("result with no transaction pending: placed_offset %0h", got.placed);
          err_cnt++;
        end else begin
          want = placement_q.pop_front();
          if (got.placed !== want.placed) begin
            $error("placed_offset expected %0h actual %0h", want.placed, got.placed);
            err_cnt++;
          end
          if (got.reused !== want.reused) begin
            $error("reused_hole expected %0b actual %0b", want.reused, got.reused);
            err_cnt++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0b actual %0b", want.status, got.status);
            err_cnt++;
          end
        end
      end
      if (took_q) begin
        req = '{mode: mode_i, len: item_length_i, ofs: item_offset_i};
        want = serve_request(req);
        placement_q.push_back(want);
        xfer_cnt++;
        if (req.mode == bfh_pkg::MODE_RELEASE) begin
          release_cnt++;
          if (want.status) drop_cnt++;
        end else if (want.reused) begin
          reuse_cnt++;
        end else begin
          append_cnt++;
        end
      end
      if (rst_ni && cfg_we_i) begin
        case (cfg_idx_i)
          bfh_pkg::REG_MIN_SPLIT: begin
            split_min = cfg_wdata_i[bfh_pkg::LEN_W-1:0];
          end
          bfh_pkg::REG_DATA_START: begin
            tail_ofs = cfg_wdata_i[bfh_pkg::OFS_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // driver: presents the next pending request once the current one is taken
  always @(negedge clk_i) begin : drv
    request_t nxt;
    if (rst_ni && (!start_i || took_q)) begin
      if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt = request_q.pop_front();
        start_i       <= 1'b1;
        mode_i        <= nxt.mode;
        item_length_i <= nxt.len;
        item_offset_i <= nxt.ofs;
      end else begin
        start_i       <= 1'b0;
        mode_i        <= 1'($urandom);
        item_length_i <= bfh_pkg::LEN_W'($urandom);
        item_offset_i <= bfh_pkg::OFS_W'($urandom);
      end
    end
  end

  function automatic request_t random_request(int unsigned rel_pct);
    request_t    req;
    int unsigned pick;
    req.mode = ($urandom_range(99) < rel_pct) ? bfh_pkg::MODE_RELEASE : bfh_pkg::MODE_ALLOC;
    pick = $urandom_range(99);
    // mostly small sizes so that allocations hit released holes and exact fits
    if (pick < 70) req.len = bfh_pkg::LEN_W'($urandom_range(0, 40));
    else if (pick < 90) req.len = bfh_pkg::LEN_W'($urandom_range(0, 300));
    else req.len = bfh_pkg::LEN_W'($urandom);
    if ($urandom_range(99) < 20) begin
      req.ofs = bfh_pkg::OFS_W'(32'h7fff_ffff - $urandom_range(0, 100));
    end else begin
      req.ofs = bfh_pkg::OFS_W'($urandom);
    end
    return req;
  endfunction

  task automatic wait_idle();
    while (request_q.size() != 0 || start_i || placement_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [bfh_pkg::CFG_IDX_W-1:0] idx,
                           logic [bfh_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(logic [bfh_pkg::LEN_W-1:0] split_val,
                           logic [bfh_pkg::OFS_W-1:0] start_val,
                           int unsigned n, int unsigned idle_val);
    int unsigned rel_pct;
    write_reg(bfh_pkg::REG_MIN_SPLIT,
              bfh_pkg::CFG_W'(({$urandom} & 32'h7fff_0000) | {16'd0, split_val}));
    write_reg(bfh_pkg::REG_DATA_START, start_val);
    idle_pct = idle_val;
    rel_pct = 45;
    for (int unsigned k = 0; k < n; k++) begin
      // swing between filling and draining the hole table
      if (k % 50 == 0) begin
        case ($urandom_range(2))
          0: rel_pct = 20;
          1: rel_pct = 45;
          default: rel_pct = 80;
        endcase
      end
      request_q.push_back(random_request(rel_pct));
    end
    wait_idle();
    phase_cnt++;
  endtask

  initial begin : stim
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: extremes, zero-size hole, split, wrap, full table
    request_q.push_back('{bfh_pkg::MODE_ALLOC, 16'd0, 31'd0});
    request_q.push_back('{bfh_pkg::MODE_ALLOC, 16'hffff, 31'h7fff_ffff});
    request_q.push_back('{bfh_pkg::MODE_RELEASE, 16'd0, 31'd100});
    request_q.push_back('{bfh_pkg::MODE_ALLOC, 16'd0, 31'd0});
    request_q.push_back('{bfh_pkg::MODE_RELEASE, 16'd20, 31'd200});
    request_q.push_back('{bfh_pkg::MODE_ALLOC, 16'd5, 31'd0});
    request_q.push_back('{bfh_pkg::MODE_RELEASE, 16'd40, 31'h7fff_fff0});
    request_q.push_back('{bfh_pkg::MODE_ALLOC, 16'd20, 31'd0});
    request_q.push_back('{bfh_pkg::MODE_RELEASE, 16'hffff, 31'h7fff_ffff});
    for (int unsigned k = 1; k < 17; k++) begin
      request_q.push_back('{bfh_pkg::MODE_RELEASE, 16'((k % 4) * 7), 31'(k * 1000)});
    end
    wait_idle();
    phase_cnt++;

    run_phase(16'd0, 31'h7fff_ff00, 300, 11);
    run_phase(16'hffff, 31'd0, 300, 0);
    run_phase(16'($urandom_range(0, 20)), 31'($urandom), 450, 11);
    run_phase(16'd5, 31'h7fff_ffff, 450, 11);

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (placement_q.size() != 0) begin
      $error("%0d results never arrived", placement_q.size());
      err_cnt++;
    end
    $display("covered %0d transactions over %0d register settings", xfer_cnt, phase_cnt);
    $display("  %0d hole reuses, %0d appends, %0d releases of which %0d hit a full table",
             reuse_cnt, append_cnt, release_cnt, drop_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bfh_pkg.sv
hw/rtl/bfh_cell.sv
hw/rtl/best_fit_hole_allocator_core.sv
tb/sv/best_fit_hole_allocator_core_tb.sv
